/* hw/rtl/eirf_pkg.sv */
// ----------------------------------------------------------------------------
// eirf_pkg
// Shared types and constants for the inbound ESP replay filter.
// ----------------------------------------------------------------------------
package eirf_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ACCEPT       = 3'd0,
    ST_NO_SA        = 3'd1,
    ST_TOO_SHORT    = 3'd2,
    ST_MISALIGNED   = 3'd3,
    ST_SPI_MISMATCH = 3'd4,
    ST_SEQ_ZERO     = 3'd5,
    ST_TOO_OLD      = 3'd6,
    ST_DUPLICATE    = 3'd7
  } status_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SA_VALID       = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXPECTED_SPI   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INTEGRITY_SHA1 = 2'd2;

  // Length constants (bytes)
  localparam logic [15:0] HDR_IV_BYTES  = 16'd24;
  localparam logic [15:0] TRAILER_BYTES = 16'd2;
  localparam logic [15:0] ICV_SHA1      = 16'd12;
  localparam logic [15:0] ICV_SHA256    = 16'd16;
  localparam int unsigned BlockLog2     = 4;

  // Queue between classifier and window stage
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueDepth = 2 ** QueuePtrW;

  typedef struct packed {
    status_e     status;
    logic [31:0] seq;
    logic [15:0] ct_len;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* hw/rtl/esp_inbound_replay_filter.sv */
// ----------------------------------------------------------------------------
// esp_inbound_replay_filter
// Inbound ESP header filter: SA, length, alignment, SPI and sequence checks followed by a
// sliding anti-replay window.
// ----------------------------------------------------------------------------
// Ordering: an accepted header is registered in the queue, then its result in the
//   window stage's output register, which holds its result while out_stall_i is high.
// Throughput: one header per cycle, unless the output stalls and the queue fills.
// Reset: registers return to their reset values, window and highest
//   sequence number clear, the queue and the output register empty.
module esp_inbound_replay_filter #(
  parameter int unsigned WINDOW_SIZE = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [eirf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [31:0]                  packet_spi_i,
  input  logic [31:0]                  packet_seq_i,
  input  logic [15:0]                  packet_length_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic [15:0]                  ciphertext_length_o
);

  logic                    push;
  logic                    pop;
  eirf_pkg::queue_entry_t  entry;
  eirf_pkg::queue_entry_t  head;
  eirf_pkg::queue_status_t q_stat;

  eirf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .packet_spi_i    (packet_spi_i),
    .packet_seq_i    (packet_seq_i),
    .packet_length_i (packet_length_i),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .entry_o         (entry)
  );

  eirf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  eirf_back #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_i              (head),
    .q_stat_i            (q_stat),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .ciphertext_length_o (ciphertext_length_o)
  );

  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !q_stat.empty)
    else $error("accepted transaction missing from queue");

  a_accept_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == eirf_pkg::ST_ACCEPT) |-> ciphertext_length_o[3:0] == 4'd0)
    else $error("accepted packet with misaligned ciphertext");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == eirf_pkg::ST_TOO_SHORT) |-> ciphertext_length_o == 16'd0)
    else $error("short packet with nonzero ciphertext length");

endmodule

/* hw/rtl/eirf_front.sv */
// ----------------------------------------------------------------------------
// eirf_front
// Holds the configuration registers and classifies each header before the
// replay window check.
// ----------------------------------------------------------------------------
module eirf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [eirf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [31:0]                  packet_spi_i,
  input  logic [31:0]                  packet_seq_i,
  input  logic [15:0]                  packet_length_i,
  input  eirf_pkg::queue_status_t      q_stat_i,
  output logic                         push_o,
  output eirf_pkg::queue_entry_t       entry_o
);

  logic        sa_valid_q;
  logic [31:0] expected_spi_q;
  logic        integrity_sha1_q;

  logic [15:0] icv_len;
  logic        long_enough;
  logic [15:0] ct_len;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_valid_q       <= 1'b0;
      expected_spi_q   <= '0;
      integrity_sha1_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        eirf_pkg::CFG_SA_VALID:       sa_valid_q       <= cfg_data_i[0];
        eirf_pkg::CFG_EXPECTED_SPI:   expected_spi_q   <= cfg_data_i;
        eirf_pkg::CFG_INTEGRITY_SHA1: integrity_sha1_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    icv_len     = integrity_sha1_q ? eirf_pkg::ICV_SHA1 : eirf_pkg::ICV_SHA256;
    long_enough = packet_length_i >= (eirf_pkg::HDR_IV_BYTES + eirf_pkg::TRAILER_BYTES
                                      + icv_len);
    ct_len      = long_enough ? (packet_length_i - eirf_pkg::HDR_IV_BYTES - icv_len)
                              : 16'd0;

    entry_o.seq    = packet_seq_i;
    entry_o.ct_len = ct_len;
    // first failing check wins; a pass is left for the window stage
    if (!sa_valid_q) begin
      entry_o.status = eirf_pkg::ST_NO_SA;
    end else if (!long_enough) begin
      entry_o.status = eirf_pkg::ST_TOO_SHORT;
    end else if (ct_len[eirf_pkg::BlockLog2-1:0] != '0) begin
      entry_o.status = eirf_pkg::ST_MISALIGNED;
    end else if (packet_spi_i != expected_spi_q) begin
      entry_o.status = eirf_pkg::ST_SPI_MISMATCH;
    end else if (packet_seq_i == '0) begin
      entry_o.status = eirf_pkg::ST_SEQ_ZERO;
    end else begin
      entry_o.status = eirf_pkg::ST_ACCEPT;
    end
  end

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

endmodule

/* hw/rtl/eirf_queue.sv */
// ----------------------------------------------------------------------------
// eirf_queue
// Short FIFO of classified headers between the front and the window stage.
// ----------------------------------------------------------------------------
module eirf_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  eirf_pkg::queue_entry_t  entry_i,
  input  logic                    pop_i,
  output eirf_pkg::queue_entry_t  head_o,
  output eirf_pkg::queue_status_t stat_o
);

  eirf_pkg::queue_entry_t mem_q [eirf_pkg::QueueDepth];

  logic [eirf_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [eirf_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [eirf_pkg::QueuePtrW:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = count_q == (eirf_pkg::QueuePtrW + 1)'(eirf_pkg::QueueDepth);
  assign stat_o.empty = count_q == '0;

endmodule

/* hw/rtl/eirf_back.sv */
// ----------------------------------------------------------------------------
// eirf_back
// Runs the sliding anti-replay window check and holds the result register.
// ----------------------------------------------------------------------------
module eirf_back #(
  parameter int unsigned WINDOW_SIZE = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  eirf_pkg::queue_entry_t  head_i,
  input  eirf_pkg::queue_status_t q_stat_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              status_o,
  output logic [15:0]             ciphertext_length_o
);

  localparam int unsigned GapW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam logic [WINDOW_SIZE-1:0] WinOne = WINDOW_SIZE'(1);

  logic [31:0]            highest_q, highest_d;
  logic [WINDOW_SIZE-1:0] window_q, window_d;
  logic                   out_valid_q;
  eirf_pkg::status_e      status_q, status_d;
  logic [15:0]            ct_len_q;

  logic                   ahead;
  logic [31:0]            diff;
  logic                   far;
  logic [GapW-1:0]        shamt;
  logic [WINDOW_SIZE-1:0] bit_vec;

  assign pop_o = !q_stat_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    ahead     = head_i.seq > highest_q;
    diff      = ahead ? (head_i.seq - highest_q) : (highest_q - head_i.seq);
    far       = diff >= 32'(WINDOW_SIZE);
    shamt     = diff[GapW-1:0];
    bit_vec   = WinOne << shamt;
    highest_d = highest_q;
    window_d  = window_q;
    status_d  = head_i.status;
    if (head_i.status == eirf_pkg::ST_ACCEPT) begin
      if (highest_q == '0) begin
        // first packet: start the window at its own number
        highest_d = head_i.seq;
        window_d  = WinOne;
      end else if (ahead) begin
        highest_d = head_i.seq;
        window_d  = far ? WinOne : ((window_q << shamt) | WinOne);
      end else if (far) begin
        status_d = eirf_pkg::ST_TOO_OLD;
      end else if ((window_q & bit_vec) != '0) begin
        status_d = eirf_pkg::ST_DUPLICATE;
      end else begin
        window_d = window_q | bit_vec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highest_q   <= '0;
      window_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        highest_q   <= highest_d;
        window_q    <= window_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= status_d;
      ct_len_q <= head_i.ct_len;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign ciphertext_length_o = ct_len_q;

endmodule
